### hdl/parachute_fill_time_defines.svh
// ----------------------------------------------------------------------------
// Parachute fill time: assertion macros
// Concurrent checks on clk, optionally masked while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PARACHUTE_FILL_TIME_DEFINES_SVH
`define PARACHUTE_FILL_TIME_DEFINES_SVH
`ifndef ASSERT_OFF
// check masked during reset
`define PFT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("parachute_fill_time: check failed");
// check that holds at every edge
`define PFT_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("parachute_fill_time: check failed");
`else
`define PFT_ASSERT(lbl, prop)
`define PFT_CHECK(lbl, prop)
`endif
`endif

### hdl/pft_pkg.sv
// ----------------------------------------------------------------------------
// Parachute fill time package
// Item types, fixed-point widths, pipeline depths and exp2 root constants.
// ----------------------------------------------------------------------------
package pft_pkg;

	// fixed point
	localparam int FRAC_BITS = 16;
	localparam int FB_DIAM   = 8;
	localparam int FB_SPEED  = 8;
	localparam int LOG_FB    = 30;
	localparam int LOG_W     = 40;
	localparam int LX_W      = 37;
	localparam int PP_SPLIT  = 19;
	localparam int DIV_W     = 2 * ((LOG_W + FRAC_BITS + 1) / 2);
	localparam int DIV_STG   = DIV_W / 2;
	localparam int EXP_W     = DIV_W + 2;

	// fill modes
	localparam logic [1:0] FM_REEFED  = 2'd0;
	localparam logic [1:0] FM_DISREEF = 2'd1;
	localparam logic [1:0] FM_FULL    = 2'd2;

	// pipeline stage map
	localparam int LOG_LAT    = LOG_FB + 2;
	localparam int EXP_LAT    = LOG_FB + 2;
	localparam int ST_PRE     = 2;
	localparam int ST_LOG     = ST_PRE + LOG_LAT;
	localparam int ST_A       = ST_LOG + 1;
	localparam int ST_B       = ST_A + 1;
	localparam int ST_C       = ST_B + DIV_STG + 1;
	localparam int ST_EXP     = ST_C + EXP_LAT;
	localparam int PIPE_DEPTH = ST_EXP + 1;

	typedef struct packed {
		logic [1:0]         fill_mode;
		logic               first_stage;
		logic [16:0]        area_now;
		logic [16:0]        area_before;
		logic [23:0]        fill_coeff;
		logic signed [19:0] speed_power;
		logic [19:0]        overfill_gain;
		logic [19:0]        inflate_gain;
		logic [17:0]        speed;
	} in_item_t;

	typedef struct packed {
		logic [31:0] base_time;
		logic [31:0] full_time;
		logic        clipped;
	} out_item_t;

	// per-item control carried along the pipe
	typedef struct packed {
		logic signed [19:0] ev;
		logic [19:0]        k;
		logic               first;
		logic               nz;
		logic               have_s;
	} side_t;

	// floor integer square root
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] xx;
		r  = '0;
		b  = 64'd1 << 62;
		xx = x;
		for (int i = 0; i < 32; i++) begin
			if (xx >= r + b) begin
				xx = xx - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-idx) in Q1.LOG_FB, each root from the previous one
	function automatic logic [LOG_FB:0] exp_root(input int idx);
		logic [63:0] root;
		root = 64'd2 << LOG_FB;
		for (int i = 1; i <= idx; i++)
			root = isqrt64(root << LOG_FB);
		return root[LOG_FB:0];
	endfunction

endpackage

### hdl/pft_log2.sv
// ----------------------------------------------------------------------------
// Pipelined base-2 logarithm
// Leading-one search, normalize, then one mantissa squaring per stage.
// ----------------------------------------------------------------------------
module pft_log2 import pft_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic [LX_W-1:0]         x,
	input  logic [5:0]              fb,
	output logic signed [LOG_W-1:0] lg
);

	logic [5:0]          p_in;
	logic [LX_W-1:0]     x_a;
	logic [5:0]          p_a;
	logic [5:0]          fb_a;
	logic [LX_W+LOG_FB-1:0] norm;

	logic [LOG_FB:0]     m_s    [0:LOG_FB];
	logic [LOG_FB-1:0]   frac_s [0:LOG_FB];
	logic signed [7:0]   eo_s   [0:LOG_FB];

	// leading one position
	always_comb begin
		p_in = '0;
		for (int b = 0; b < LX_W; b++)
			if (x[b]) p_in = 6'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_a  <= x;
			p_a  <= p_in;
			fb_a <= fb;
		end
	end

	// normalize so the leading one sits at bit LOG_FB
	assign norm = {x_a, {LOG_FB{1'b0}}} >> p_a;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= norm[LOG_FB:0];
			frac_s[0] <= '0;
			eo_s[0]   <= $signed({2'b00, p_a}) - $signed({2'b00, fb_a});
		end
	end

	// one fraction bit per stage
	for (genvar i = 1; i <= LOG_FB; i++) begin : g_sq
		logic [2*LOG_FB+1:0] prod;
		logic [LOG_FB+1:0]   t;
		assign prod = m_s[i-1] * m_s[i-1];
		assign t    = prod[2*LOG_FB+1:LOG_FB];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i]    <= t[LOG_FB+1] ? t[LOG_FB+1:1] : t[LOG_FB:0];
				frac_s[i] <= {frac_s[i-1][LOG_FB-2:0], t[LOG_FB+1]};
				eo_s[i]   <= eo_s[i-1];
			end
		end
	end

	assign lg = $signed({{(LOG_W-LOG_FB-8){eo_s[LOG_FB][7]}}, eo_s[LOG_FB],
		frac_s[LOG_FB]});

endmodule

### hdl/pft_exp2.sv
// ----------------------------------------------------------------------------
// Pipelined base-2 exponential into unsigned Q16.16
// Splits integer and fraction, one root multiply per stage, final shift.
// ----------------------------------------------------------------------------
module pft_exp2 import pft_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [EXP_W-1:0] lv,
	output logic [31:0]             val,
	output logic                    sat
);

	logic signed [EXP_W-LOG_FB-1:0] n_in;
	logic signed [EXP_W-LOG_FB:0]   e_in;
	logic [4:0]                     rsh_in;

	logic [LOG_FB:0]   m_s     [0:LOG_FB];
	logic [LOG_FB-1:0] f_s     [0:LOG_FB];
	logic              sat_s   [0:LOG_FB];
	logic              left_s  [0:LOG_FB];
	logic [4:0]        rsh_s   [0:LOG_FB];

	// exponent of the result and its output shift
	assign n_in = lv[EXP_W-1:LOG_FB];
	assign e_in = (EXP_W-LOG_FB+1)'(n_in + FRAC_BITS);

	always_comb begin
		if (e_in >= LOG_FB)
			rsh_in = '0;
		else if (e_in <= LOG_FB - 31)
			rsh_in = 5'd31;
		else
			rsh_in = 5'(LOG_FB - e_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= (LOG_FB+1)'(1) << LOG_FB;
			f_s[0]    <= lv[LOG_FB-1:0];
			sat_s[0]  <= (e_in >= 32);
			left_s[0] <= (e_in == LOG_FB + 1);
			rsh_s[0]  <= rsh_in;
		end
	end

	// multiply in 2^(2^-i) where fraction bit is set
	for (genvar i = 1; i <= LOG_FB; i++) begin : g_mul
		localparam logic [LOG_FB:0] ROOT = exp_root(i);
		logic [2*LOG_FB+1:0] prod;
		assign prod = m_s[i-1] * ROOT;
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i]    <= f_s[i-1][LOG_FB-i] ? prod[2*LOG_FB:LOG_FB] : m_s[i-1];
				f_s[i]    <= f_s[i-1];
				sat_s[i]  <= sat_s[i-1];
				left_s[i] <= left_s[i-1];
				rsh_s[i]  <= rsh_s[i-1];
			end
		end
	end

	// final alignment
	always_ff @(posedge clk) begin
		if (en) begin
			sat <= sat_s[LOG_FB];
			if (sat_s[LOG_FB])
				val <= '1;
			else if (left_s[LOG_FB])
				val <= {m_s[LOG_FB], 1'b0};
			else
				val <= {1'b0, m_s[LOG_FB]} >> rsh_s[LOG_FB];
		end
	end

endmodule

### hdl/parachute_fill_time.sv
// ----------------------------------------------------------------------------
// Parachute fill time
// Stage fill time and total fill time in the log2 domain, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   stage_valid/stage_stall/stage_data carry one reefing stage description.
//   times_valid/times_stall/times_data return base_time, full_time, clipped.
//   cfg_valid/cfg_ready/cfg_data write the nominal diameter (always ready);
//   write it only while no item is in flight.
// Throughput: one item per cycle while the pipe is not stalled, one result per
//   item. Depth is set by the 30-stage log2 and exp2 squaring/multiply chains
//   and the 28-stage radix-4 divide by k.
// Stall: when a finished result waits on times_stall the whole pipe holds
//   and stage_stall is raised in the same cycle; nothing is lost or repeated.
// Reset: arst_n clears the valid bits and the diameter to 0; results
//   appear only for items accepted after reset.
// ----------------------------------------------------------------------------
`include "parachute_fill_time_defines.svh"

module parachute_fill_time import pft_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        stage_valid,
	output logic        stage_stall,
	input  in_item_t    stage_data,
	output logic        times_valid,
	input  logic        times_stall,
	output out_item_t   times_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic en;
	logic [15:0] nominal_diameter_q;

	logic  vld_s  [1:PIPE_DEPTH];
	side_t side_s [1:PIPE_DEPTH];

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nominal_diameter_q <= '0;
		else if (cfg_valid && cfg_ready)
			nominal_diameter_q <= cfg_data;
	end

	// global pipe advance
	assign en          = !(vld_s[PIPE_DEPTH] && times_stall);
	assign stage_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '{default: 1'b0};
		end else if (en) begin
			vld_s[1] <= stage_valid;
			for (int j = 2; j <= PIPE_DEPTH; j++)
				vld_s[j] <= vld_s[j-1];
		end
	end

	// stage 1: delta, clamps, scale product
	logic [16:0] prev_in;
	logic [16:0] dr_in;
	logic [17:0] v_in;
	logic [19:0] k_in;

	logic [16:0] dr_s1, an_s1, ab_s1;
	logic [17:0] v_s1;
	logic [23:0] c_s1;
	logic [15:0] d_s1;
	logic [19:0] o_s1;
	logic [36:0] prod_s1;
	logic        first_s1;
	logic        have_s_in;

	assign prev_in = stage_data.first_stage ? '0 : stage_data.area_before;
	assign v_in    = (stage_data.speed == '0) ? 18'd1 : stage_data.speed;
	assign k_in    = (stage_data.inflate_gain == '0) ? 20'd1 : stage_data.inflate_gain;

	always_comb begin
		case (stage_data.fill_mode)
			FM_REEFED:  dr_in = stage_data.area_now;
			FM_DISREEF: dr_in = (stage_data.area_now > prev_in) ?
				stage_data.area_now - prev_in : '0;
			FM_FULL:    dr_in = 17'(1) << FRAC_BITS;
			default:    dr_in = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1    <= dr_in;
			an_s1    <= stage_data.area_now;
			ab_s1    <= stage_data.area_before;
			v_s1     <= v_in;
			c_s1     <= stage_data.fill_coeff;
			d_s1     <= nominal_diameter_q;
			o_s1     <= stage_data.overfill_gain;
			prod_s1  <= stage_data.overfill_gain * stage_data.area_now;
			first_s1 <= stage_data.first_stage;
		end
	end

	// side data travels with the item
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1].ev     <= stage_data.speed_power;
			side_s[1].k      <= k_in;
			side_s[1].first  <= stage_data.first_stage;
			side_s[1].nz     <= (dr_in != '0) && (stage_data.fill_coeff != '0) &&
				(nominal_diameter_q != '0);
			side_s[1].have_s <= 1'b0;
			// scale flag joins at stage 2
			side_s[2].ev     <= side_s[1].ev;
			side_s[2].k      <= side_s[1].k;
			side_s[2].first  <= side_s[1].first;
			side_s[2].nz     <= side_s[1].nz;
			side_s[2].have_s <= have_s_in;
			for (int j = 3; j <= PIPE_DEPTH; j++)
				side_s[j] <= side_s[j-1];
		end
	end

	// stage 2: scale numerator and denominator
	logic signed [38:0] num_in;
	logic signed [17:0] den_in;
	logic [LX_W-1:0]    num_abs;

	assign num_in  = $signed({2'b00, prod_s1}) -
		$signed({6'b0, ab_s1, {FRAC_BITS{1'b0}}});
	assign den_in  = $signed({1'b0, an_s1}) - $signed({1'b0, ab_s1});
	assign num_abs = num_in[38] ? LX_W'(-num_in) : num_in[LX_W-1:0];

	always_comb begin
		if (first_s1)
			have_s_in = (o_s1 != '0);
		else
			have_s_in = (an_s1 != ab_s1) && (num_in != '0) &&
				(num_in[38] == den_in[17]);
	end

	logic [LX_W-1:0] xc_s2, xd_s2, xdr_s2, xv_s2, xa_s2, xden_s2;
	logic [5:0]      fba_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s2   <= LX_W'(c_s1);
			xd_s2   <= LX_W'(d_s1);
			xdr_s2  <= LX_W'(dr_s1);
			xv_s2   <= LX_W'(v_s1);
			xa_s2   <= first_s1 ? LX_W'(o_s1) : num_abs;
			fba_s2  <= first_s1 ? 6'(FRAC_BITS) : 6'(2 * FRAC_BITS);
			xden_s2 <= den_in[17] ? LX_W'(-den_in) : LX_W'(den_in[16:0]);
		end
	end

	// log2 lanes
	logic signed [LOG_W-1:0] lc, ld, ldr, lv, la, lden;

	pft_log2 u_log_c   (.clk(clk), .en(en), .x(xc_s2),   .fb(6'(FRAC_BITS)), .lg(lc));
	pft_log2 u_log_d   (.clk(clk), .en(en), .x(xd_s2),   .fb(6'(FB_DIAM)),   .lg(ld));
	pft_log2 u_log_dr  (.clk(clk), .en(en), .x(xdr_s2),  .fb(6'(FRAC_BITS)), .lg(ldr));
	pft_log2 u_log_v   (.clk(clk), .en(en), .x(xv_s2),   .fb(6'(FB_SPEED)),  .lg(lv));
	pft_log2 u_log_s   (.clk(clk), .en(en), .x(xa_s2),   .fb(fba_s2),        .lg(la));
	pft_log2 u_log_den (.clk(clk), .en(en), .x(xden_s2), .fb(6'(FRAC_BITS)), .lg(lden));

	// stage A: log sums and split velocity power product
	logic signed [LOG_W-1:0]        sum_s35, ls_s35;
	logic signed [39:0]             pp_lo_s35;
	logic signed [40:0]             pp_hi_s35;
	logic signed [19:0]             ev_a;

	assign ev_a = side_s[ST_LOG].ev;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s35   <= lc + ld + (ldr >>> 1);
			pp_lo_s35 <= ev_a * $signed({1'b0, lv[PP_SPLIT-1:0]});
			pp_hi_s35 <= ev_a * $signed(lv[LOG_W-1:PP_SPLIT]);
			ls_s35    <= side_s[ST_LOG].first ? la : la - lden;
		end
	end

	// stage B: base exponent and divider load
	logic signed [60:0]      hi_ext, evp, evl, l1_full;
	logic [LOG_W-1:0]        ls_mag;

	assign hi_ext  = pp_hi_s35;
	assign evp     = (hi_ext <<< PP_SPLIT) + pp_lo_s35;
	assign evl     = evp >>> FRAC_BITS;
	assign l1_full = sum_s35 - evl;
	assign ls_mag  = ls_s35[LOG_W-1] ? LOG_W'(-ls_s35) : ls_s35;

	logic [DIV_W-1:0]        dvd_s [0:DIV_STG];
	logic [19:0]             rem_s [0:DIV_STG];
	logic signed [LOG_W-1:0] l1_s  [0:DIV_STG];
	logic                    neg_s [0:DIV_STG];

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= DIV_W'({ls_mag, {FRAC_BITS{1'b0}}});
			rem_s[0] <= '0;
			l1_s[0]  <= l1_full[LOG_W-1:0];
			neg_s[0] <= ls_s35[LOG_W-1];
		end
	end

	// restoring divide by k, two quotient bits per stage
	for (genvar j = 1; j <= DIV_STG; j++) begin : g_div
		logic [19:0]      kd;
		logic [20:0]      r1, r2;
		logic             q1, q2;
		logic [19:0]      r1b, r2b;
		logic [DIV_W-1:0] d1;
		assign kd  = side_s[ST_B + j - 1].k;
		assign r1  = {rem_s[j-1], dvd_s[j-1][DIV_W-1]};
		assign q1  = (r1 >= {1'b0, kd});
		assign r1b = q1 ? 20'(r1 - {1'b0, kd}) : r1[19:0];
		assign d1  = {dvd_s[j-1][DIV_W-2:0], q1};
		assign r2  = {r1b, d1[DIV_W-1]};
		assign q2  = (r2 >= {1'b0, kd});
		assign r2b = q2 ? 20'(r2 - {1'b0, kd}) : r2[19:0];
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[j] <= {d1[DIV_W-2:0], q2};
				rem_s[j] <= r2b;
				l1_s[j]  <= l1_s[j-1];
				neg_s[j] <= neg_s[j-1];
			end
		end
	end

	// stage C: total fill exponent
	logic signed [DIV_W:0]   q_sgn;
	logic signed [EXP_W-1:0] l1_c, l2_s65, l1_s65;

	assign q_sgn = neg_s[DIV_STG] ? -$signed({1'b0, dvd_s[DIV_STG]}) :
		$signed({1'b0, dvd_s[DIV_STG]});
	assign l1_c  = l1_s[DIV_STG];

	always_ff @(posedge clk) begin
		if (en) begin
			l1_s65 <= l1_c;
			l2_s65 <= l1_c + q_sgn;
		end
	end

	// exp2 lanes
	logic [31:0] base_val, full_val;
	logic        base_sat, full_sat;

	pft_exp2 u_exp_base (.clk(clk), .en(en), .lv(l1_s65), .val(base_val), .sat(base_sat));
	pft_exp2 u_exp_full (.clk(clk), .en(en), .lv(l2_s65), .val(full_val), .sat(full_sat));

	// output register with zero gating
	out_item_t out_s98;
	side_t     sd_e;

	assign sd_e = side_s[ST_EXP];

	always_ff @(posedge clk) begin
		if (en) begin
			out_s98.base_time <= sd_e.nz ? base_val : '0;
			out_s98.full_time <= (sd_e.nz && sd_e.have_s) ? full_val : '0;
			out_s98.clipped   <= sd_e.nz && (base_sat || (sd_e.have_s && full_sat));
		end
	end

	assign times_valid = vld_s[PIPE_DEPTH];
	assign times_data  = out_s98;

	// checks
	`PFT_ASSERT(a_zero_operand, times_valid && !side_s[PIPE_DEPTH].nz |-> times_data.base_time == '0 && times_data.full_time == '0 && !times_data.clipped)
	`PFT_ASSERT(a_no_scale, times_valid && !side_s[PIPE_DEPTH].have_s |-> times_data.full_time == '0)
	`PFT_CHECK(a_clip_is_max, times_valid && times_data.clipped |-> (times_data.base_time == '1 || times_data.full_time == '1))

endmodule
